@@ rtl/assert_macros.svh @@
// Assertion macros used by the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is held off while reset is high.
`define TISP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("Parser port check failed.");

// Clocked assertion that is also checked during reset.
`define TISP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("Parser port check failed during reset.");

`endif

@@ rtl/tisp_pkg.sv @@
// Types and constants of the time and image stream parser.
package tisp_pkg;

  localparam logic [1:0] KIND_TIME  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_BYTE  = 2'd2;
  localparam logic [1:0] KIND_DONE  = 2'd3;

  localparam logic [3:0] PH_SECOND = 4'd0;
  localparam logic [3:0] PH_YEAR   = 4'd6;
  localparam logic [3:0] PH_SIZE   = 4'd7;
  localparam logic [3:0] PH_CRC    = 4'd8;
  localparam logic [3:0] PH_IMAGE  = 4'd9;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT,
    ST_READ,
    ST_LOAD,
    ST_BYTE
  } state_t;

  typedef struct packed {
    logic [7:0]  byte_value;
    logic [31:0] packet_index;
    logic [31:0] last_index;
    logic        last_in_packet;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  second;
    logic [7:0]  minute;
    logic [7:0]  hour;
    logic [7:0]  day;
    logic [7:0]  weekday;
    logic [7:0]  month;
    logic [15:0] year;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic        last;
  } result_t;

  typedef struct packed {
    logic       clear;
    logic       start;
    logic [7:0] data;
  } crc_cmd_t;

  typedef struct packed {
    logic        busy;
    logic [31:0] value;
  } crc_stat_t;

endpackage

@@ rtl/time_and_image_stream_parser.sv @@
// Top level of the time and image stream parser.
// A header byte that produces no result leaves the block idle for the next byte, and a beat
// that produces a single result holds the block until that result is taken. When an image
// chunk fills, each buffered byte passes through the chunk buffer read, the load, then the
// bit-serial CRC-32 unit that all bytes share, plus any output stall, and a done result may
// follow the last byte. The input is not ready while results are pending.
module time_and_image_stream_parser #(
  parameter int CHUNK_BYTES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  tisp_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output tisp_pkg::result_t result
);
  import tisp_pkg::*;

  localparam int FW = $clog2(CHUNK_BYTES + 1);
  localparam int AW = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;

  state_t state, state_next;

  logic [3:0]    phase, phase_next;
  logic [31:0]   field_shift, field_shift_next;
  logic [2:0]    field_count, field_count_next;
  logic [7:0]    time_bytes [6];
  logic [7:0]    time_bytes_next [6];
  logic [31:0]   image_size, image_size_next;
  logic [31:0]   received_count, received_count_next;
  logic [31:0]   expected_crc, expected_crc_next;
  logic [FW-1:0] chunk_fill, chunk_fill_next;
  logic          drop_rest, drop_rest_next;
  logic          mid_packet, mid_packet_next;
  logic [FW-1:0] flush_cnt, flush_cnt_next;
  logic [FW-1:0] flush_idx, flush_idx_next;
  logic          done_pend, done_pend_next;
  logic          lastp_q, lastp_q_next;
  result_t       res, res_next;

  logic [7:0]    mem [CHUNK_BYTES];
  logic [7:0]    rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;

  crc_cmd_t  crc_cmd;
  crc_stat_t crc_stat;

  logic          emit;
  logic          flush;
  logic          clr;
  logic          restart;
  logic          final_end;
  logic          last_byte;
  logic [31:0]   crc_eff;
  logic [31:0]   sh;
  logic [2:0]    cnt;
  logic [2:0]    need_hdr;
  logic [31:0]   remain;
  logic [FW-1:0] need_img;
  logic [FW-1:0] fill1;
  logic [31:0]   recv_sum;

  tisp_crc u_crc (
    .clk  (clk),
    .rst  (rst),
    .cmd  (crc_cmd),
    .stat (crc_stat)
  );

  assign final_end = item.last_in_packet && (item.packet_index == item.last_index);
  assign last_byte = (flush_idx == flush_cnt - FW'(1));

  always_comb begin
    phase_next          = phase;
    field_shift_next    = field_shift;
    field_count_next    = field_count;
    time_bytes_next     = time_bytes;
    image_size_next     = image_size;
    received_count_next = received_count;
    expected_crc_next   = expected_crc;
    chunk_fill_next     = chunk_fill;
    drop_rest_next      = drop_rest;
    mid_packet_next     = mid_packet;
    flush_cnt_next      = flush_cnt;
    flush_idx_next      = flush_idx;
    done_pend_next      = done_pend;
    lastp_q_next        = lastp_q;
    res_next            = res;
    mem_we              = 1'b0;
    mem_waddr           = chunk_fill[AW-1:0];
    crc_cmd             = '0;
    crc_cmd.data        = rdata;
    emit                = 1'b0;
    flush               = 1'b0;
    clr                 = 1'b0;
    restart             = 1'b0;
    crc_eff             = crc_stat.value;
    sh                  = 32'h0;
    cnt                 = 3'd0;
    need_hdr            = 3'd1;
    remain              = 32'h0;
    need_img            = '0;
    fill1               = '0;
    recv_sum            = 32'h0;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          mid_packet_next = !item.last_in_packet;
          lastp_q_next    = item.last_in_packet;
          if (drop_rest) begin
            if (item.last_in_packet) begin
              drop_rest_next = 1'b0;
            end
          end else begin
            restart = !mid_packet && (item.packet_index == 32'h0);
            if (restart) begin
              phase_next          = PH_SECOND;
              field_shift_next    = 32'h0;
              field_count_next    = 3'd0;
              time_bytes_next     = '{default: 8'h0};
              image_size_next     = 32'h0;
              received_count_next = 32'h0;
              expected_crc_next   = 32'h0;
              chunk_fill_next     = '0;
              crc_cmd.clear       = 1'b1;
              crc_eff             = 32'h0;
            end
            if (item.packet_index <= item.last_index) begin
              if (phase_next != PH_IMAGE) begin
                sh = field_shift_next |
                     ({24'h0, item.byte_value} << {field_count_next[1:0], 3'b000});
                cnt = field_count_next + 3'd1;
                if (phase_next == PH_YEAR) begin
                  need_hdr = 3'd2;
                end else if (phase_next == PH_SIZE || phase_next == PH_CRC) begin
                  need_hdr = 3'd4;
                end
                if (cnt >= need_hdr) begin
                  field_shift_next = 32'h0;
                  field_count_next = 3'd0;
                  if (phase_next < PH_YEAR) begin
                    time_bytes_next[phase_next[2:0]] = sh[7:0];
                    phase_next = phase_next + 4'd1;
                  end else if (phase_next == PH_YEAR) begin
                    res_next         = '0;
                    res_next.kind    = KIND_TIME;
                    res_next.second  = time_bytes_next[0];
                    res_next.minute  = time_bytes_next[1];
                    res_next.hour    = time_bytes_next[2];
                    res_next.day     = time_bytes_next[3];
                    res_next.weekday = time_bytes_next[4];
                    res_next.month   = time_bytes_next[5];
                    res_next.year    = sh[15:0];
                    res_next.last    = 1'b1;
                    emit             = 1'b1;
                    phase_next       = PH_SIZE;
                  end else if (phase_next == PH_SIZE) begin
                    image_size_next = sh;
                    phase_next      = PH_CRC;
                  end else begin
                    expected_crc_next = sh;
                    phase_next        = PH_IMAGE;
                    if (image_size_next != 32'h0) begin
                      res_next        = '0;
                      res_next.kind   = KIND_START;
                      res_next.word_a = image_size_next;
                      res_next.word_b = sh;
                      res_next.last   = 1'b1;
                      emit            = 1'b1;
                    end
                  end
                  if (final_end) begin
                    clr = 1'b1;
                  end else if (phase_next == PH_IMAGE && image_size_next == 32'h0 &&
                               !item.last_in_packet) begin
                    res_next        = '0;
                    res_next.kind   = KIND_DONE;
                    res_next.word_a = {31'h0, expected_crc_next == 32'h0};
                    res_next.word_b = crc_eff;
                    res_next.last   = 1'b1;
                    emit            = 1'b1;
                    clr             = 1'b1;
                    drop_rest_next  = 1'b1;
                  end
                end else begin
                  field_shift_next = sh;
                  field_count_next = cnt;
                  if (final_end) begin
                    res_next        = '0;
                    res_next.kind   = KIND_DONE;
                    res_next.word_b = crc_eff;
                    res_next.last   = 1'b1;
                    emit            = 1'b1;
                    clr             = 1'b1;
                  end
                end
              end else begin
                remain = image_size_next - received_count_next;
                if (remain == 32'h0) begin
                  res_next        = '0;
                  res_next.kind   = KIND_DONE;
                  res_next.word_a = {31'h0, crc_eff == expected_crc_next};
                  res_next.word_b = crc_eff;
                  res_next.last   = 1'b1;
                  emit            = 1'b1;
                  clr             = 1'b1;
                  drop_rest_next  = !item.last_in_packet;
                end else begin
                  need_img  = (remain < 32'(CHUNK_BYTES)) ? remain[FW-1:0]
                                                          : FW'(CHUNK_BYTES);
                  mem_we    = 1'b1;
                  mem_waddr = chunk_fill_next[AW-1:0];
                  fill1     = chunk_fill_next + FW'(1);
                  if (fill1 >= need_img) begin
                    recv_sum            = received_count_next + 32'(fill1);
                    received_count_next = recv_sum;
                    chunk_fill_next     = '0;
                    flush_cnt_next      = fill1;
                    flush_idx_next      = '0;
                    done_pend_next      = (recv_sum >= image_size_next) || final_end;
                    flush               = 1'b1;
                  end else begin
                    chunk_fill_next = fill1;
                    if (final_end) begin
                      res_next        = '0;
                      res_next.kind   = KIND_DONE;
                      res_next.word_b = crc_eff;
                      res_next.last   = 1'b1;
                      emit            = 1'b1;
                      clr             = 1'b1;
                    end
                  end
                end
              end
            end
          end
        end
      end
      ST_LOAD: begin
        res_next        = '0;
        res_next.kind   = KIND_BYTE;
        res_next.word_a = {24'h0, rdata};
        res_next.last   = last_byte && !done_pend;
        crc_cmd.start   = 1'b1;
      end
      ST_BYTE: begin
        if (result_ready && !crc_stat.busy) begin
          if (last_byte) begin
            if (done_pend) begin
              res_next        = '0;
              res_next.kind   = KIND_DONE;
              res_next.word_a = {31'h0, crc_stat.value == expected_crc};
              res_next.word_b = crc_stat.value;
              res_next.last   = 1'b1;
              clr             = 1'b1;
              drop_rest_next  = !lastp_q;
            end
          end else begin
            flush_idx_next = flush_idx + FW'(1);
          end
        end
      end
      ST_EMIT, ST_READ: begin
      end
      default: begin
      end
    endcase
    if (clr) begin
      phase_next          = PH_SECOND;
      field_shift_next    = 32'h0;
      field_count_next    = 3'd0;
      time_bytes_next     = '{default: 8'h0};
      image_size_next     = 32'h0;
      received_count_next = 32'h0;
      expected_crc_next   = 32'h0;
      chunk_fill_next     = '0;
      crc_cmd.clear       = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          if (emit) begin
            state_next = ST_EMIT;
          end else if (flush) begin
            state_next = ST_READ;
          end
        end
      end
      ST_EMIT: begin
        if (result_ready) begin
          state_next = ST_IDLE;
        end
      end
      ST_READ: state_next = ST_LOAD;
      ST_LOAD: state_next = ST_BYTE;
      ST_BYTE: begin
        if (result_ready && !crc_stat.busy) begin
          if (!last_byte) begin
            state_next = ST_READ;
          end else if (done_pend) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready   = (state == ST_IDLE);
    result_valid = (state == ST_EMIT) || (state == ST_BYTE && !crc_stat.busy);
  end

  assign result = res;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= item.byte_value;
    end
    rdata <= mem[flush_idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    res       <= res_next;
    flush_cnt <= flush_cnt_next;
    flush_idx <= flush_idx_next;
    lastp_q   <= lastp_q_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      phase          <= PH_SECOND;
      field_shift    <= 32'h0;
      field_count    <= 3'd0;
      time_bytes     <= '{default: 8'h0};
      image_size     <= 32'h0;
      received_count <= 32'h0;
      expected_crc   <= 32'h0;
      chunk_fill     <= '0;
      drop_rest      <= 1'b0;
      mid_packet     <= 1'b0;
      done_pend      <= 1'b0;
    end else begin
      state          <= state_next;
      phase          <= phase_next;
      field_shift    <= field_shift_next;
      field_count    <= field_count_next;
      time_bytes     <= time_bytes_next;
      image_size     <= image_size_next;
      received_count <= received_count_next;
      expected_crc   <= expected_crc_next;
      chunk_fill     <= chunk_fill_next;
      drop_rest      <= drop_rest_next;
      mid_packet     <= mid_packet_next;
      done_pend      <= done_pend_next;
    end
  end

endmodule

@@ rtl/tisp_crc.sv @@
// Bit-serial CRC-32 unit that folds one byte into the running checksum.
module tisp_crc (
  input  logic                 clk,
  input  logic                 rst,
  input  tisp_pkg::crc_cmd_t   cmd,
  output tisp_pkg::crc_stat_t  stat
);
  import tisp_pkg::*;

  logic [31:0] crc;
  logic [2:0]  cnt;
  logic        busy;
  logic [31:0] crc_step;

  assign crc_step = {1'b0, crc[31:1]} ^ (crc[0] ? CRC_POLY : 32'h0);

  always_ff @(posedge clk) begin
    if (rst) begin
      crc  <= 32'hFFFFFFFF;
      cnt  <= 3'd0;
      busy <= 1'b0;
    end else if (cmd.clear) begin
      crc  <= 32'hFFFFFFFF;
      cnt  <= 3'd0;
      busy <= 1'b0;
    end else if (cmd.start) begin
      crc  <= crc ^ {24'h0, cmd.data};
      cnt  <= 3'd0;
      busy <= 1'b1;
    end else if (busy) begin
      crc <= crc_step;
      cnt <= cnt + 3'd1;
      if (cnt == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

  assign stat.busy  = busy;
  assign stat.value = ~crc;

endmodule

@@ rtl/tisp_checker.sv @@
// Port checker of the time and image stream parser and its bind.
`include "assert_macros.svh"

module tisp_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_ready,
  input logic              result_valid,
  input logic              result_ready,
  input tisp_pkg::result_t result
);
  import tisp_pkg::*;

  `TISP_ASSERT(a_result_hold, result_valid && !result_ready |=> result_valid && $stable(result))
  `TISP_ASSERT_ALWAYS(a_reset_idle, rst |=> item_ready && !result_valid)
  `TISP_ASSERT(a_one_side, !(item_ready && result_valid))
  `TISP_ASSERT(a_byte_clean, result_valid && result.kind == KIND_BYTE |-> result.word_b == 32'h0)
  `TISP_ASSERT(a_done_flag, result_valid && result.kind == KIND_DONE |-> result.last)

endmodule

bind time_and_image_stream_parser tisp_checker u_tisp_checker (.*);
